FILE: sv/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers used by the allocator top level. Define NO_ASSERTIONS
// to compile every use to nothing.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, disabled during reset
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`else

`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

FILE: sv/iesa_pkg.sv
// ----------------------------------------------------------------------------
// Interrupt event slot allocator package
// Widths, operation and status codes, and the structs shared by the slot RAM,
// the scan unit and the top level.
// ----------------------------------------------------------------------------
package iesa_pkg;

    // Table geometry
    localparam int SLOT_COUNT   = 96;
    localparam int SLOT_W       = 7;
    localparam logic [SLOT_W-1:0] SLOT_NIL  = SLOT_W'(SLOT_COUNT);
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(SLOT_COUNT - 1);

    // Priority handling
    localparam int MAX_PRIORITY = 15;
    localparam int PRIO_W       = $clog2(MAX_PRIORITY + 1);
    localparam int PRIO_SHIFT   = 4;

    // Field widths
    localparam int OP_W       = 3;
    localparam int EVENT_W    = 9;
    localparam int REQ_PRIO_W = 8;
    localparam int HANDLER_W  = 16;
    localparam int CONTEXT_W  = 32;
    localparam int STATUS_W   = 3;
    localparam int PBYTE_W    = 8;

    // Operation codes
    localparam logic [OP_W-1:0] OP_REGISTER   = 3'd0;
    localparam logic [OP_W-1:0] OP_UNREGISTER = 3'd1;
    localparam logic [OP_W-1:0] OP_SET_PRIO   = 3'd2;
    localparam logic [OP_W-1:0] OP_LOOKUP     = 3'd3;
    localparam logic [OP_W-1:0] OP_DISPATCH   = 3'd4;

    // Status codes
    localparam logic [STATUS_W-1:0] STAT_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] STAT_INVALID   = 3'd1;
    localparam logic [STATUS_W-1:0] STAT_EXISTS    = 3'd2;
    localparam logic [STATUS_W-1:0] STAT_NO_SLOT   = 3'd3;
    localparam logic [STATUS_W-1:0] STAT_NOT_FOUND = 3'd4;

    // One slot entry as held in the RAM
    typedef struct packed {
        logic [EVENT_W-1:0]   event_num;
        logic [PRIO_W-1:0]    prio;
        logic [HANDLER_W-1:0] handler;
        logic [CONTEXT_W-1:0] ctx;
    } t_entry;

    // RAM write request: full entry or priority only
    typedef struct packed {
        logic              en_all;
        logic              en_prio;
        logic [SLOT_W-1:0] addr;
        t_entry            data;
    } t_ram_wr;

    // Scan unit report
    typedef struct packed {
        logic              done;
        logic              found;
        logic [SLOT_W-1:0] idx;
        logic              free_vld;
        logic [SLOT_W-1:0] free_idx;
    } t_scan_res;

    // One result transaction
    typedef struct packed {
        logic [STATUS_W-1:0]  status;
        logic [SLOT_W-1:0]    slot;
        logic [PBYTE_W-1:0]   pbyte;
        logic [HANDLER_W-1:0] handler;
        logic [CONTEXT_W-1:0] ctx;
    } t_result;

endpackage

FILE: sv/interrupt_event_slot_allocator.sv
// ----------------------------------------------------------------------------
// Interrupt event slot allocator
// Maps event numbers to interrupt slots: register, unregister, set priority,
// lookup and dispatch, with a serial first-fit scan over the slot RAM.
// ----------------------------------------------------------------------------
//
//  Channel | Handshake                 | Payload
//  --------+---------------------------+----------------------------------------
//  input   | i_in_valid / o_in_stall   | operation, event, priority, tags, slot
//  output  | o_out_valid / i_out_stall | status, slot, priority byte, tags
//
//  Register, unregister, set priority and lookup scan the slot RAM through its
//  single read port, one slot per cycle, and finish at the first match or at
//  the last slot. Dispatch reads its slot on acceptance and passes through a
//  dispatch state; rejected arguments and unknown codes go straight to the
//  result state. Reset clears the slot valid bits directly; no clearing pass.
//  Input stalls while a transaction is in work; a waiting result does not
//  block acceptance of the next transaction.
//
`include "assert_macros.svh"

module interrupt_event_slot_allocator (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [iesa_pkg::OP_W-1:0]           i_operation,
    input  logic [iesa_pkg::EVENT_W-1:0]        i_event_number,
    input  logic [iesa_pkg::REQ_PRIO_W-1:0]     i_requested_priority,
    input  logic [iesa_pkg::HANDLER_W-1:0]      i_handler_tag,
    input  logic [iesa_pkg::CONTEXT_W-1:0]      i_context_tag,
    input  logic [iesa_pkg::SLOT_W-1:0]         i_dispatch_slot,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic [iesa_pkg::STATUS_W-1:0]       o_status,
    output logic [iesa_pkg::SLOT_W-1:0]         o_slot_index,
    output logic [iesa_pkg::PBYTE_W-1:0]        o_priority_byte,
    output logic [iesa_pkg::HANDLER_W-1:0]      o_handler_out,
    output logic [iesa_pkg::CONTEXT_W-1:0]      o_context_out
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DISP,
        ST_RESP
    } t_state;

    t_state                             r_state;
    logic [iesa_pkg::OP_W-1:0]          r_op;
    logic [iesa_pkg::EVENT_W-1:0]       r_event;
    logic [iesa_pkg::REQ_PRIO_W-1:0]    r_prio;
    logic [iesa_pkg::HANDLER_W-1:0]     r_handler;
    logic [iesa_pkg::CONTEXT_W-1:0]     r_ctx;
    logic [iesa_pkg::SLOT_W-1:0]        r_dslot;
    logic [iesa_pkg::SLOT_COUNT-1:0]    r_used;
    iesa_pkg::t_result                  r_res;
    iesa_pkg::t_result                  r_out;
    logic                               r_out_valid;

    logic                               w_accept;
    logic                               w_prio_bad;
    logic                               w_start;
    logic                               w_disp_rd;
    logic                               w_scan_done;
    logic                               w_clear;
    logic [iesa_pkg::PBYTE_W-1:0]       w_pbyte;
    iesa_pkg::t_result                  w_imm;
    iesa_pkg::t_result                  w_fin;
    iesa_pkg::t_result                  w_disp;
    iesa_pkg::t_ram_wr                  w_wr;
    iesa_pkg::t_entry                   w_rd_data;
    iesa_pkg::t_scan_res                w_scan;
    logic                               w_scan_rd_en;
    logic [iesa_pkg::SLOT_W-1:0]        w_scan_rd_addr;
    logic                               w_rd_en;
    logic [iesa_pkg::SLOT_W-1:0]        w_rd_addr;

    assign o_in_stall = (r_state != ST_IDLE);
    assign w_accept   = i_in_valid && (r_state == ST_IDLE);
    assign w_prio_bad = i_requested_priority >
                        iesa_pkg::REQ_PRIO_W'(iesa_pkg::MAX_PRIORITY);

    // Decode an incoming transaction: reject, answer at once, start a scan or read a slot
    always_comb begin
        w_imm      = '0;
        w_imm.slot = iesa_pkg::SLOT_NIL;
        w_start    = 1'b0;
        w_disp_rd  = 1'b0;
        case (i_operation)
            iesa_pkg::OP_REGISTER: begin
                if ((i_handler_tag == '0) || w_prio_bad) begin
                    w_imm.status = iesa_pkg::STAT_INVALID;
                end else begin
                    w_start = 1'b1;
                end
            end
            iesa_pkg::OP_UNREGISTER, iesa_pkg::OP_LOOKUP: begin
                w_start = 1'b1;
            end
            iesa_pkg::OP_SET_PRIO: begin
                if (w_prio_bad) begin
                    w_imm.status = iesa_pkg::STAT_INVALID;
                end else begin
                    w_start = 1'b1;
                end
            end
            iesa_pkg::OP_DISPATCH: begin
                // out-of-range slot: ok, no slot, zero tags
                if (int'(i_dispatch_slot) < iesa_pkg::SLOT_COUNT) begin
                    w_disp_rd = 1'b1;
                end
            end
            default: begin
                w_imm.status = iesa_pkg::STAT_INVALID;
            end
        endcase
    end

    // Share the RAM read port between the scan and a dispatch read
    always_comb begin
        if (w_accept && w_disp_rd) begin
            w_rd_en   = 1'b1;
            w_rd_addr = i_dispatch_slot;
        end else begin
            w_rd_en   = w_scan_rd_en;
            w_rd_addr = w_scan_rd_addr;
        end
    end

    // Finish a scanned operation: build the result and any RAM update
    always_comb begin
        w_scan_done = (r_state == ST_SCAN) && w_scan.done;
        w_pbyte     = iesa_pkg::PBYTE_W'(r_prio << iesa_pkg::PRIO_SHIFT);
        w_wr        = '0;
        w_clear     = 1'b0;
        w_fin       = '0;
        w_fin.slot  = iesa_pkg::SLOT_NIL;
        case (r_op)
            iesa_pkg::OP_REGISTER: begin
                if (w_scan.found) begin
                    w_fin.status = iesa_pkg::STAT_EXISTS;
                end else if (w_scan.free_vld) begin
                    w_wr.en_all         = w_scan_done;
                    w_wr.addr           = w_scan.free_idx;
                    w_wr.data.event_num = r_event;
                    w_wr.data.prio      = iesa_pkg::PRIO_W'(r_prio);
                    w_wr.data.handler   = r_handler;
                    w_wr.data.ctx       = r_ctx;
                    w_fin.slot          = w_scan.free_idx;
                    w_fin.pbyte         = w_pbyte;
                end else begin
                    w_fin.status = iesa_pkg::STAT_NO_SLOT;
                end
            end
            iesa_pkg::OP_UNREGISTER: begin
                if (w_scan.found) begin
                    w_clear    = w_scan_done;
                    w_fin.slot = w_scan.idx;
                end else begin
                    w_fin.status = iesa_pkg::STAT_NOT_FOUND;
                end
            end
            iesa_pkg::OP_SET_PRIO: begin
                if (w_scan.found) begin
                    w_wr.en_prio   = w_scan_done;
                    w_wr.addr      = w_scan.idx;
                    w_wr.data.prio = iesa_pkg::PRIO_W'(r_prio);
                    w_fin.slot     = w_scan.idx;
                    w_fin.pbyte    = w_pbyte;
                end else begin
                    w_fin.status = iesa_pkg::STAT_NOT_FOUND;
                end
            end
            iesa_pkg::OP_LOOKUP: begin
                if (w_scan.found) begin
                    w_fin.slot = w_scan.idx;
                end
            end
            default: begin
            end
        endcase
    end

    // Dispatch result: a free slot reads as zero tags
    always_comb begin
        w_disp      = '0;
        w_disp.slot = r_dslot;
        if (r_used[r_dslot]) begin
            w_disp.handler = w_rd_data.handler;
            w_disp.ctx     = w_rd_data.ctx;
        end
    end

    // Sequencer, slot valid bits and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_used      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // Load a finished result, or drop the one just taken
            if ((r_state == ST_RESP) && (!r_out_valid || !i_out_stall)) begin
                r_out       <= r_res;
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (w_wr.en_all) begin
                r_used[w_wr.addr] <= 1'b1;
            end
            if (w_clear) begin
                r_used[w_scan.idx] <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (w_accept) begin
                        r_op      <= i_operation;
                        r_event   <= i_event_number;
                        r_prio    <= i_requested_priority;
                        r_handler <= i_handler_tag;
                        r_ctx     <= i_context_tag;
                        r_dslot   <= i_dispatch_slot;
                        r_res     <= w_imm;
                        if (w_start) begin
                            r_state <= ST_SCAN;
                        end else if (w_disp_rd) begin
                            r_state <= ST_DISP;
                        end else begin
                            r_state <= ST_RESP;
                        end
                    end
                end
                ST_SCAN: begin
                    if (w_scan.done) begin
                        r_res   <= w_fin;
                        r_state <= ST_RESP;
                    end
                end
                ST_DISP: begin
                    r_res   <= w_disp;
                    r_state <= ST_RESP;
                end
                ST_RESP: begin
                    if (!r_out_valid || !i_out_stall) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    iesa_slot_ram u_ram (
        .i_clk     (i_clk),
        .i_wr      (w_wr),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    iesa_scan u_scan (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_accept && w_start),
        .i_key      (r_event),
        .i_used     (r_used),
        .i_rd_event (w_rd_data.event_num),
        .o_rd_en    (w_scan_rd_en),
        .o_rd_addr  (w_scan_rd_addr),
        .o_res      (w_scan)
    );

    assign o_out_valid     = r_out_valid;
    assign o_status        = r_out.status;
    assign o_slot_index    = r_out.slot;
    assign o_priority_byte = r_out.pbyte;
    assign o_handler_out   = r_out.handler;
    assign o_context_out   = r_out.ctx;

    // Checks on scan results and allocation
    `ASSERT_IMPLY(a_hit_is_used, i_clk, i_rst_n, w_scan.done && w_scan.found, r_used[w_scan.idx], "scan matched a free slot")
    `ASSERT_IMPLY(a_free_is_free, i_clk, i_rst_n, w_scan.done && w_scan.free_vld, !r_used[w_scan.free_idx], "scan reported a used slot as free")
    `ASSERT_NEXT(a_alloc_marks_used, i_clk, i_rst_n, w_wr.en_all, r_used[$past(w_wr.addr)], "allocated slot not marked used")

endmodule

FILE: sv/iesa_slot_ram.sv
// ----------------------------------------------------------------------------
// Slot RAM
// Event, priority, handler and context store. One write port with a
// priority-only enable, one registered read port.
// ----------------------------------------------------------------------------
module iesa_slot_ram (
    input  logic                              i_clk,
    input  iesa_pkg::t_ram_wr                 i_wr,
    input  logic                              i_rd_en,
    input  logic [iesa_pkg::SLOT_W-1:0]       i_rd_addr,
    output iesa_pkg::t_entry                  o_rd_data
);

    logic [iesa_pkg::EVENT_W-1:0]   r_mem_event   [iesa_pkg::SLOT_COUNT];
    logic [iesa_pkg::PRIO_W-1:0]    r_mem_prio    [iesa_pkg::SLOT_COUNT];
    logic [iesa_pkg::HANDLER_W-1:0] r_mem_handler [iesa_pkg::SLOT_COUNT];
    logic [iesa_pkg::CONTEXT_W-1:0] r_mem_ctx     [iesa_pkg::SLOT_COUNT];
    iesa_pkg::t_entry               r_rd_data;

    // Write the full entry, or the priority field alone
    always_ff @(posedge i_clk) begin
        if (i_wr.en_all) begin
            r_mem_event[i_wr.addr]   <= i_wr.data.event_num;
            r_mem_handler[i_wr.addr] <= i_wr.data.handler;
            r_mem_ctx[i_wr.addr]     <= i_wr.data.ctx;
        end
        if (i_wr.en_all || i_wr.en_prio) begin
            r_mem_prio[i_wr.addr] <= i_wr.data.prio;
        end
    end

    // Registered read
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data.event_num <= r_mem_event[i_rd_addr];
            r_rd_data.prio      <= r_mem_prio[i_rd_addr];
            r_rd_data.handler   <= r_mem_handler[i_rd_addr];
            r_rd_data.ctx       <= r_mem_ctx[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: sv/iesa_scan.sv
// ----------------------------------------------------------------------------
// Slot scan unit
// Walks the slot RAM from slot 0 upward, one read per cycle, and compares each
// entry against the key. Reports the first matching slot and the first free
// slot seen on the way.
// ----------------------------------------------------------------------------
module iesa_scan (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_start,
    input  logic [iesa_pkg::EVENT_W-1:0]          i_key,
    input  logic [iesa_pkg::SLOT_COUNT-1:0]       i_used,
    input  logic [iesa_pkg::EVENT_W-1:0]          i_rd_event,
    output logic                                  o_rd_en,
    output logic [iesa_pkg::SLOT_W-1:0]           o_rd_addr,
    output iesa_pkg::t_scan_res                   o_res
);

    logic                          r_busy;
    logic                          r_issue;
    logic [iesa_pkg::SLOT_W-1:0]   r_rd_addr;
    logic                          r_cmp_vld;
    logic [iesa_pkg::SLOT_W-1:0]   r_cmp_addr;
    iesa_pkg::t_scan_res           r_res;
    logic                          w_hit;
    logic                          w_free;
    logic                          w_last;

    // Compare the entry whose read data just arrived
    always_comb begin
        w_hit  = r_cmp_vld && i_used[r_cmp_addr] && (i_rd_event == i_key);
        w_free = r_cmp_vld && !i_used[r_cmp_addr];
        w_last = r_cmp_vld && (r_cmp_addr == iesa_pkg::LAST_SLOT);
    end

    // Issue reads, track first free slot, stop on first match or last slot
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy     <= 1'b0;
            r_issue    <= 1'b0;
            r_rd_addr  <= '0;
            r_cmp_vld  <= 1'b0;
            r_cmp_addr <= '0;
            r_res      <= '0;
        end else if (i_start) begin
            r_busy         <= 1'b1;
            r_issue        <= 1'b1;
            r_rd_addr      <= '0;
            r_cmp_vld      <= 1'b0;
            r_res.done     <= 1'b0;
            r_res.found    <= 1'b0;
            r_res.idx      <= iesa_pkg::SLOT_NIL;
            r_res.free_vld <= 1'b0;
            r_res.free_idx <= iesa_pkg::SLOT_NIL;
        end else if (r_busy) begin
            if (w_free && !r_res.free_vld) begin
                r_res.free_vld <= 1'b1;
                r_res.free_idx <= r_cmp_addr;
            end
            if (w_hit || w_last) begin
                // report and go idle
                r_busy     <= 1'b0;
                r_issue    <= 1'b0;
                r_cmp_vld  <= 1'b0;
                r_res.done <= 1'b1;
                if (w_hit) begin
                    r_res.found <= 1'b1;
                    r_res.idx   <= r_cmp_addr;
                end
            end else begin
                r_cmp_vld  <= r_issue;
                r_cmp_addr <= r_rd_addr;
                if (r_issue) begin
                    if (r_rd_addr == iesa_pkg::LAST_SLOT) begin
                        r_issue <= 1'b0;
                    end else begin
                        r_rd_addr <= r_rd_addr + 1'b1;
                    end
                end
            end
        end else begin
            r_res.done <= 1'b0;
        end
    end

    assign o_rd_en   = r_busy && r_issue;
    assign o_rd_addr = r_rd_addr;
    assign o_res     = r_res;

endmodule

FILE: tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Slot allocator testbench
// Sends register, unregister, set-priority, lookup and dispatch transactions
// into the interrupt event slot allocator. A mirror of the slot table in the
// testbench works out each result, and every result is checked field by field
// in order. The run goes through idle and stall phases, a full table and a
// long output hold.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int CLK_HALF_NS   = 6;
    localparam int RESET_CYCLES  = 4;
    localparam int CYCLE_LIMIT   = 1000000;
    localparam int SETTLE_CYCLES = 120;
    localparam int LONG_HOLD     = 800;
    localparam int PHASE_ITEMS   = 140;

    localparam logic [iesa_pkg::OP_W-1:0]      OP_LAST_CODE = '1;
    localparam logic [iesa_pkg::EVENT_W-1:0]   EV_MAX       = '1;
    localparam logic [iesa_pkg::HANDLER_W-1:0] NO_HANDLER   = '0;
    localparam logic [iesa_pkg::HANDLER_W-1:0] HANDLER_MAX  = '1;

    // DUT ports
    logic                            i_clk                = 1'b0;
    logic                            i_rst_n              = 1'b0;
    logic                            i_in_valid           = 1'b0;
    logic                            o_in_stall;
    logic [iesa_pkg::OP_W-1:0]       i_operation          = '0;
    logic [iesa_pkg::EVENT_W-1:0]    i_event_number       = '0;
    logic [iesa_pkg::REQ_PRIO_W-1:0] i_requested_priority = '0;
    logic [iesa_pkg::HANDLER_W-1:0]  i_handler_tag        = '0;
    logic [iesa_pkg::CONTEXT_W-1:0]  i_context_tag        = '0;
    logic [iesa_pkg::SLOT_W-1:0]     i_dispatch_slot      = '0;
    logic                            o_out_valid;
    logic                            i_out_stall          = 1'b0;
    logic [iesa_pkg::STATUS_W-1:0]   o_status;
    logic [iesa_pkg::SLOT_W-1:0]     o_slot_index;
    logic [iesa_pkg::PBYTE_W-1:0]    o_priority_byte;
    logic [iesa_pkg::HANDLER_W-1:0]  o_handler_out;
    logic [iesa_pkg::CONTEXT_W-1:0]  o_context_out;

    // Mirror of the slot table
    logic                           tbl_used    [iesa_pkg::SLOT_COUNT];
    logic [iesa_pkg::EVENT_W-1:0]   tbl_ev      [iesa_pkg::SLOT_COUNT];
    logic [iesa_pkg::PRIO_W-1:0]    tbl_prio    [iesa_pkg::SLOT_COUNT];
    logic [iesa_pkg::HANDLER_W-1:0] tbl_handler [iesa_pkg::SLOT_COUNT];
    logic [iesa_pkg::CONTEXT_W-1:0] tbl_ctx     [iesa_pkg::SLOT_COUNT];

    iesa_pkg::t_result slot_replies_q[$];
    iesa_pkg::t_result want_reply;

    int fail_count    = 0;
    int send_idle_pct = 0;
    int stall_pct     = 0;
    int hold_len      = 0;
    int hold_left     = 0;
    int cycle_count   = 0;

    interrupt_event_slot_allocator i_dut (.*);

    // Generate the clock
    always begin
        #CLK_HALF_NS i_clk = 1'b1;
        #CLK_HALF_NS i_clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Slot table mirror
    // ------------------------------------------------------------------------
    function automatic void clear_slot(input int s);
        tbl_used[s]    = 1'b0;
        tbl_ev[s]      = '0;
        tbl_prio[s]    = '0;
        tbl_handler[s] = '0;
        tbl_ctx[s]     = '0;
    endfunction

    function automatic int find_event(input logic [iesa_pkg::EVENT_W-1:0] ev);
        for (int i = 0; i < iesa_pkg::SLOT_COUNT; i++) begin
            if (tbl_used[i] && tbl_ev[i] == ev) begin
                return i;
            end
        end
        return iesa_pkg::SLOT_COUNT;
    endfunction

    function automatic int find_free();
        for (int i = 0; i < iesa_pkg::SLOT_COUNT; i++) begin
            if (!tbl_used[i]) begin
                return i;
            end
        end
        return iesa_pkg::SLOT_COUNT;
    endfunction

    // Apply one transaction to the mirror and return the result it gives
    function automatic iesa_pkg::t_result apply_slot_op(
        input logic [iesa_pkg::OP_W-1:0]       op,
        input logic [iesa_pkg::EVENT_W-1:0]    ev,
        input logic [iesa_pkg::REQ_PRIO_W-1:0] prio,
        input logic [iesa_pkg::HANDLER_W-1:0]  hnd,
        input logic [iesa_pkg::CONTEXT_W-1:0]  ctx,
        input logic [iesa_pkg::SLOT_W-1:0]     dslot
    );
        iesa_pkg::t_result r;
        int                s;
        r        = '0;
        r.status = iesa_pkg::STAT_OK;
        r.slot   = iesa_pkg::SLOT_NIL;
        case (op)
            iesa_pkg::OP_REGISTER: begin
                if (hnd == NO_HANDLER || prio > iesa_pkg::MAX_PRIORITY) begin
                    r.status = iesa_pkg::STAT_INVALID;
                end else if (find_event(ev) < iesa_pkg::SLOT_COUNT) begin
                    r.status = iesa_pkg::STAT_EXISTS;
                end else begin
                    s = find_free();
                    if (s >= iesa_pkg::SLOT_COUNT) begin
                        r.status = iesa_pkg::STAT_NO_SLOT;
                    end else begin
                        tbl_used[s]    = 1'b1;
                        tbl_ev[s]      = ev;
                        tbl_prio[s]    = iesa_pkg::PRIO_W'(prio);
                        tbl_handler[s] = hnd;
                        tbl_ctx[s]     = ctx;
                        r.slot         = iesa_pkg::SLOT_W'(s);
                        r.pbyte        = prio << iesa_pkg::PRIO_SHIFT;
                    end
                end
            end
            iesa_pkg::OP_UNREGISTER: begin
                s = find_event(ev);
                if (s >= iesa_pkg::SLOT_COUNT) begin
                    r.status = iesa_pkg::STAT_NOT_FOUND;
                end else begin
                    clear_slot(s);
                    r.slot = iesa_pkg::SLOT_W'(s);
                end
            end
            iesa_pkg::OP_SET_PRIO: begin
                if (prio > iesa_pkg::MAX_PRIORITY) begin
                    r.status = iesa_pkg::STAT_INVALID;
                end else begin
                    s = find_event(ev);
                    if (s >= iesa_pkg::SLOT_COUNT) begin
                        r.status = iesa_pkg::STAT_NOT_FOUND;
                    end else begin
                        tbl_prio[s] = iesa_pkg::PRIO_W'(prio);
                        r.slot      = iesa_pkg::SLOT_W'(s);
                        r.pbyte     = prio << iesa_pkg::PRIO_SHIFT;
                    end
                end
            end
            iesa_pkg::OP_LOOKUP: begin
                r.slot = iesa_pkg::SLOT_W'(find_event(ev));
            end
            iesa_pkg::OP_DISPATCH: begin
                // out-of-range slots are ignored
                if (dslot < iesa_pkg::SLOT_COUNT) begin
                    r.slot    = dslot;
                    r.handler = tbl_handler[dslot];
                    r.ctx     = tbl_ctx[dslot];
                end
            end
            default: begin
                r.status = iesa_pkg::STAT_INVALID;
            end
        endcase
        return r;
    endfunction

    // Random field values at their port widths
    function automatic logic [iesa_pkg::OP_W-1:0] any_op();
        return iesa_pkg::OP_W'($urandom);
    endfunction

    function automatic logic [iesa_pkg::EVENT_W-1:0] any_event();
        return iesa_pkg::EVENT_W'($urandom);
    endfunction

    function automatic logic [iesa_pkg::REQ_PRIO_W-1:0] any_prio();
        return iesa_pkg::REQ_PRIO_W'($urandom);
    endfunction

    function automatic logic [iesa_pkg::REQ_PRIO_W-1:0] legal_prio();
        return iesa_pkg::REQ_PRIO_W'($urandom_range(iesa_pkg::MAX_PRIORITY));
    endfunction

    function automatic logic [iesa_pkg::HANDLER_W-1:0] any_handler();
        return iesa_pkg::HANDLER_W'($urandom);
    endfunction

    function automatic logic [iesa_pkg::SLOT_W-1:0] any_slot();
        return iesa_pkg::SLOT_W'($urandom);
    endfunction

    function automatic logic [iesa_pkg::SLOT_W-1:0] live_slot();
        return iesa_pkg::SLOT_W'($urandom_range(iesa_pkg::LAST_SLOT));
    endfunction

    // Pick an event that is not mapped yet
    function automatic logic [iesa_pkg::EVENT_W-1:0] fresh_event();
        logic [iesa_pkg::EVENT_W-1:0] ev;
        do begin
            ev = any_event();
        end while (find_event(ev) < iesa_pkg::SLOT_COUNT);
        return ev;
    endfunction

    // Pick a mapped event, or any event when the table is empty
    function automatic logic [iesa_pkg::EVENT_W-1:0] mapped_event();
        int start;
        int k;
        start = $urandom_range(iesa_pkg::SLOT_COUNT - 1);
        for (int i = 0; i < iesa_pkg::SLOT_COUNT; i++) begin
            k = (start + i) % iesa_pkg::SLOT_COUNT;
            if (tbl_used[k]) begin
                return tbl_ev[k];
            end
        end
        return any_event();
    endfunction

    function automatic logic [iesa_pkg::HANDLER_W-1:0] live_handler();
        return iesa_pkg::HANDLER_W'($urandom_range(HANDLER_MAX, 1));
    endfunction

    // ------------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------------
    // Offer one transaction, hold it until accepted, then log its result
    task automatic send_op(
        input logic [iesa_pkg::OP_W-1:0]       op,
        input logic [iesa_pkg::EVENT_W-1:0]    ev,
        input logic [iesa_pkg::REQ_PRIO_W-1:0] prio,
        input logic [iesa_pkg::HANDLER_W-1:0]  hnd,
        input logic [iesa_pkg::CONTEXT_W-1:0]  ctx,
        input logic [iesa_pkg::SLOT_W-1:0]     dslot
    );
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid           <= 1'b1;
        i_operation          <= op;
        i_event_number       <= ev;
        i_requested_priority <= prio;
        i_handler_tag        <= hnd;
        i_context_tag        <= ctx;
        i_dispatch_slot      <= dslot;
        do begin
            @(posedge i_clk);
        end while (o_in_stall !== 1'b0);
        slot_replies_q.push_back(apply_slot_op(op, ev, prio, hnd, ctx, dslot));
    endtask

    // Stop offering until every outstanding result has come back
    task automatic wait_replies_drained();
        i_in_valid <= 1'b0;
        while (slot_replies_q.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    // ------------------------------------------------------------------------
    // Output side
    // ------------------------------------------------------------------------
    // Stall at random, or hold off for a requested stretch
    always @(posedge i_clk) begin
        if (hold_len > 0) begin
            hold_left = hold_len;
            hold_len  = 0;
        end
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    task automatic compare_field(
        input string                          name,
        input logic [iesa_pkg::CONTEXT_W-1:0] want,
        input logic [iesa_pkg::CONTEXT_W-1:0] got
    );
        if (got !== want) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            fail_count++;
        end
    endtask

    // Check each accepted result against the oldest outstanding one
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid === 1'b1 && !i_out_stall) begin
            if (slot_replies_q.size() == 0) begin
                $error("unexpected result: status %0d, slot %0d", o_status, o_slot_index);
                fail_count++;
            end else begin
                want_reply = slot_replies_q.pop_front();
                compare_field("status", want_reply.status, o_status);
                compare_field("slot_index", want_reply.slot, o_slot_index);
                compare_field("priority_byte", want_reply.pbyte, o_priority_byte);
                compare_field("handler_out", want_reply.handler, o_handler_out);
                compare_field("context_out", want_reply.ctx, o_context_out);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    // Field extremes, every operation and every rejection path but a full table
    task automatic test_directed();
        send_idle_pct = 0;
        stall_pct     = 0;
        // first fit fills slots 0 and 1
        send_op(iesa_pkg::OP_REGISTER, 0, 0, 1, 0, 0);
        send_op(iesa_pkg::OP_REGISTER, EV_MAX,
                iesa_pkg::REQ_PRIO_W'(iesa_pkg::MAX_PRIORITY), '1, '1, '1);
        // rejected registers: already mapped, no handler, priority too high
        send_op(iesa_pkg::OP_REGISTER, 0, 3, 16'h1234, 32'h5555_aaaa, 0);
        send_op(iesa_pkg::OP_REGISTER, 7, 3, NO_HANDLER, 32'h0000_0001, 0);
        send_op(iesa_pkg::OP_REGISTER, 7,
                iesa_pkg::REQ_PRIO_W'(iesa_pkg::MAX_PRIORITY + 1), 16'h0001, 0, 0);
        send_op(iesa_pkg::OP_REGISTER, 7, '1, '1, '1, 0);
        // lookup of a mapped and an unmapped event
        send_op(iesa_pkg::OP_LOOKUP, EV_MAX, 0, 0, 0, 0);
        send_op(iesa_pkg::OP_LOOKUP, 7, 0, 0, 0, 0);
        // set priority: ok, too high, not mapped
        send_op(iesa_pkg::OP_SET_PRIO, EV_MAX, 0, 0, 0, 0);
        send_op(iesa_pkg::OP_SET_PRIO, EV_MAX, '1, 0, 0, 0);
        send_op(iesa_pkg::OP_SET_PRIO, 7, 9, 0, 0, 0);
        // dispatch: two used slots, the unused last slot, out of range
        send_op(iesa_pkg::OP_DISPATCH, 0, 0, 0, 0, 0);
        send_op(iesa_pkg::OP_DISPATCH, 0, 0, 0, 0, 1);
        send_op(iesa_pkg::OP_DISPATCH, 0, 0, 0, 0, iesa_pkg::LAST_SLOT);
        send_op(iesa_pkg::OP_DISPATCH, 0, 0, 0, 0, iesa_pkg::SLOT_NIL);
        send_op(iesa_pkg::OP_DISPATCH, 0, 0, 0, 0, '1);
        // free slot 0, free it again, dispatch the freed slot, reuse it
        send_op(iesa_pkg::OP_UNREGISTER, 0, 0, 0, 0, 0);
        send_op(iesa_pkg::OP_UNREGISTER, 0, 0, 0, 0, 0);
        send_op(iesa_pkg::OP_DISPATCH, 0, 0, 0, 0, 0);
        send_op(iesa_pkg::OP_REGISTER, 9, 5, 16'h00f0, 32'hdead_beef, 0);
        // unknown operation codes
        for (int c = iesa_pkg::OP_DISPATCH + 1; c <= OP_LAST_CODE; c++) begin
            send_op(iesa_pkg::OP_W'(c), any_event(), any_prio(), any_handler(),
                    $urandom, any_slot());
        end
        wait_replies_drained();
    endtask

    // Fill the table, hit the full case, then release about half of it
    task automatic test_table_full();
        int s;
        send_idle_pct = 10;
        stall_pct     = 10;
        while (find_free() < iesa_pkg::SLOT_COUNT) begin
            send_op(iesa_pkg::OP_REGISTER, fresh_event(), legal_prio(),
                    live_handler(), $urandom, any_slot());
        end
        // new event finds no slot; mapped event still reports exists
        send_op(iesa_pkg::OP_REGISTER, fresh_event(), legal_prio(),
                live_handler(), $urandom, any_slot());
        send_op(iesa_pkg::OP_REGISTER, tbl_ev[iesa_pkg::LAST_SLOT], legal_prio(),
                live_handler(), $urandom, any_slot());
        send_op(iesa_pkg::OP_LOOKUP, tbl_ev[iesa_pkg::LAST_SLOT], any_prio(),
                any_handler(), $urandom, any_slot());
        // free a random slot; first fit must land there
        s = $urandom_range(iesa_pkg::SLOT_COUNT - 1);
        send_op(iesa_pkg::OP_UNREGISTER, tbl_ev[s], any_prio(), any_handler(),
                $urandom, any_slot());
        send_op(iesa_pkg::OP_REGISTER, fresh_event(), legal_prio(),
                live_handler(), $urandom, any_slot());
        repeat (iesa_pkg::SLOT_COUNT / 2) begin
            send_op(iesa_pkg::OP_UNREGISTER, mapped_event(), any_prio(), any_handler(),
                    $urandom, any_slot());
        end
        wait_replies_drained();
    endtask

    // Mostly well-formed traffic on live events, with some noise
    task automatic test_random_traffic(input int n, input int idle, input int stall);
        int                           pick;
        logic [iesa_pkg::EVENT_W-1:0] ev;
        send_idle_pct = idle;
        stall_pct     = stall;
        repeat (n) begin
            pick = $urandom_range(99);
            if (pick < 28) begin
                ev = ($urandom_range(3) == 0) ? mapped_event() : fresh_event();
                send_op(iesa_pkg::OP_REGISTER, ev, legal_prio(),
                        live_handler(), $urandom, any_slot());
            end else if (pick < 48) begin
                ev = ($urandom_range(4) == 0) ? fresh_event() : mapped_event();
                send_op(iesa_pkg::OP_UNREGISTER, ev, any_prio(), any_handler(),
                        $urandom, any_slot());
            end else if (pick < 60) begin
                ev = ($urandom_range(4) == 0) ? fresh_event() : mapped_event();
                send_op(iesa_pkg::OP_SET_PRIO, ev, legal_prio(),
                        any_handler(), $urandom, any_slot());
            end else if (pick < 72) begin
                ev = ($urandom_range(2) == 0) ? fresh_event() : mapped_event();
                send_op(iesa_pkg::OP_LOOKUP, ev, any_prio(), any_handler(),
                        $urandom, any_slot());
            end else if (pick < 84) begin
                send_op(iesa_pkg::OP_DISPATCH, any_event(), any_prio(), any_handler(),
                        $urandom, live_slot());
            end else begin
                // fully random fields: bad codes, bad priorities, far slots
                send_op(any_op(), any_event(), any_prio(), any_handler(),
                        $urandom, any_slot());
            end
        end
        wait_replies_drained();
    endtask

    // Hold the output long enough that the block stalls its input
    task automatic test_output_hold();
        send_idle_pct = 0;
        stall_pct     = 0;
        hold_len      = LONG_HOLD;
        repeat (6) begin
            send_op(iesa_pkg::OP_DISPATCH, any_event(), any_prio(), any_handler(),
                    $urandom, live_slot());
            send_op(iesa_pkg::OP_LOOKUP, mapped_event(), any_prio(), any_handler(),
                    $urandom, any_slot());
        end
        wait_replies_drained();
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial begin
        for (int i = 0; i < iesa_pkg::SLOT_COUNT; i++) begin
            clear_slot(i);
        end
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_table_full();
        test_random_traffic(PHASE_ITEMS, 0, 0);
        test_output_hold();
        test_random_traffic(PHASE_ITEMS, 57, 0);
        test_random_traffic(PHASE_ITEMS, 0, 57);
        test_random_traffic(PHASE_ITEMS, 10, 10);

        // let any stray result surface
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    // End a hung run
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

FILE: sim.f
+incdir+sv
sv/iesa_pkg.sv
sv/iesa_slot_ram.sv
sv/iesa_scan.sv
sv/interrupt_event_slot_allocator.sv
tb/sv/tb_top.sv
